FILE: hdl/hamming_22_17_time_codec_defines.svh
`ifndef HAMMING_22_17_TIME_CODEC_DEFINES_SVH
`define HAMMING_22_17_TIME_CODEC_DEFINES_SVH

// Property checked on every rising clk edge outside reset.
`define H2217TC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A stalled transfer keeps valid and keeps its payload.
`define H2217TC_ASSERT_HOLD(label, valid, ready, sig, msg) \
  label: assert property (@(posedge clk) disable iff (rst) \
    ((valid) && !(ready)) |=> ((valid) && $stable(sig))) else $error(msg);

`endif

FILE: hdl/h2217tc_pkg.sv
package h2217tc_pkg;

  localparam int CODE_LEN = 22;
  localparam int DATA_LEN = 17;
  localparam int SYN_W    = 5;
  localparam int HOURS_W  = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;

  localparam int S_DATA_W = 40;
  localparam int S_USER_W = 1;
  localparam int M_DATA_W = 48;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  // Packed MSB first: hours_in lands in the lowest bits.
  typedef struct packed {
    logic [CODE_LEN-1:0] codeword_in;
    logic [SEC_W-1:0]    seconds_in;
    logic [MIN_W-1:0]    minutes_in;
    logic [HOURS_W-1:0]  hours_in;
  } in_item_t;

  typedef struct packed {
    logic                uncorrectable;
    logic                corrected;
    logic [SYN_W-1:0]    syndrome;
    logic [SEC_W-1:0]    seconds_out;
    logic [MIN_W-1:0]    minutes_out;
    logic [HOURS_W-1:0]  hours_out;
    logic [CODE_LEN-1:0] codeword_out;
  } result_t;

  // Code positions (1-based) of the data bits, most significant data bit first.
  localparam logic [SYN_W-1:0] DATA_POS [DATA_LEN] = '{
    5'd3, 5'd5, 5'd6, 5'd7, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13,
    5'd14, 5'd15, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22
  };

  // XOR of the indexes of all set positions.
  function automatic logic [SYN_W-1:0] parity_vec(input logic [CODE_LEN-1:0] cw);
    logic [SYN_W-1:0] v;
    v = '0;
    for (int p = 1; p <= CODE_LEN; p++) begin
      if (cw[p-1]) begin
        v = v ^ SYN_W'(p);
      end
    end
    return v;
  endfunction

endpackage

FILE: hdl/h2217tc_core.sv
module h2217tc_core (
  input  h2217tc_pkg::op_t      op,
  input  h2217tc_pkg::in_item_t item,
  output h2217tc_pkg::result_t  res
);
  import h2217tc_pkg::*;

  logic [DATA_LEN-1:0] enc_data;
  logic [CODE_LEN-1:0] enc_raw;
  logic [SYN_W-1:0]    enc_par;
  logic [CODE_LEN-1:0] enc_cw;
  logic [SYN_W-1:0]    syn;
  logic                in_range;
  logic [CODE_LEN-1:0] fixed_cw;
  logic [DATA_LEN-1:0] dec_data;

  assign enc_data = {item.hours_in, item.minutes_in, item.seconds_in};

  always_comb begin
    enc_raw = '0;
    for (int i = 0; i < DATA_LEN; i++) begin
      enc_raw[DATA_POS[i] - SYN_W'(1)] = enc_data[DATA_LEN-1-i];
    end
  end

  assign enc_par = parity_vec(enc_raw);

  always_comb begin
    enc_cw = enc_raw;
    for (int j = 0; j < SYN_W; j++) begin
      enc_cw[(1 << j) - 1] = enc_par[j];
    end
  end

  // Decode path: syndrome, single-bit repair, data extraction.
  assign syn      = parity_vec(item.codeword_in);
  assign in_range = (syn != '0) && (syn <= SYN_W'(CODE_LEN));

  always_comb begin
    fixed_cw = item.codeword_in;
    if (in_range) begin
      fixed_cw = item.codeword_in ^ (CODE_LEN'(1) << (syn - SYN_W'(1)));
    end
  end

  always_comb begin
    dec_data = '0;
    for (int i = 0; i < DATA_LEN; i++) begin
      dec_data[DATA_LEN-1-i] = fixed_cw[DATA_POS[i] - SYN_W'(1)];
    end
  end

  always_comb begin
    res = '0;
    case (op)
      OP_ENCODE: begin
        res.codeword_out = enc_cw;
      end
      OP_DECODE: begin
        res.hours_out     = dec_data[DATA_LEN-1 -: HOURS_W];
        res.minutes_out   = dec_data[SEC_W +: MIN_W];
        res.seconds_out   = dec_data[SEC_W-1:0];
        res.syndrome      = syn;
        res.corrected     = in_range;
        res.uncorrectable = (syn != '0) && !in_range;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

FILE: hdl/hamming_22_17_time_codec.sv
// Channel   Dir  Fields
// s_axis    in   tuser: operation; tdata: hours, minutes, seconds, codeword
// m_axis    out  tdata: codeword, hours, minutes, seconds, syndrome,
//                       corrected, uncorrectable
//
// One transfer in per cycle while the output is not stalled, one result per transfer;
// from input to output: an input register, the parity/correction logic, a result register.
// rst is synchronous and clears only the two valid flags.
// A stalled output holds its result; the input register still takes a transfer
// until both registers are full.
module hamming_22_17_time_codec (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [4:0] hours_in, [10:5] minutes_in, [16:11] seconds_in, [38:17] codeword_in
  input  logic [h2217tc_pkg::S_DATA_W-1:0] s_axis_tdata,
  // [0] operation
  input  logic [h2217tc_pkg::S_USER_W-1:0] s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [21:0] codeword_out, [26:22] hours_out, [32:27] minutes_out,
  // [38:33] seconds_out, [43:39] syndrome, [44] corrected, [45] uncorrectable
  output logic [h2217tc_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import h2217tc_pkg::*;

  logic     in_valid;
  op_t      in_op;
  in_item_t in_item;
  result_t  core_res;
  result_t  res;
  logic     out_load;

  assign out_load      = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= op_t'(s_axis_tuser[0]);
      in_item <= s_axis_tdata[$bits(in_item_t)-1:0];
    end
  end

  h2217tc_core u_core (
    .op   (in_op),
    .item (in_item),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res <= core_res;
    end
  end

  assign m_axis_tdata = {(M_DATA_W - $bits(result_t))'(0), res};

endmodule

FILE: hdl/h2217tc_checker.sv
`include "hamming_22_17_time_codec_defines.svh"

module h2217tc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [h2217tc_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import h2217tc_pkg::*;

  result_t r;
  assign r = m_axis_tdata[$bits(result_t)-1:0];

  `H2217TC_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata, "output changed while stalled")

  `H2217TC_ASSERT(a_flags_excl, (m_axis_tvalid |-> !(r.corrected && r.uncorrectable)), "corrected and uncorrectable both set")

  `H2217TC_ASSERT(a_syn_class, (m_axis_tvalid |-> ((r.corrected == ((r.syndrome != 5'd0) && (r.syndrome <= 5'd22))) && (r.uncorrectable == (r.syndrome > 5'd22)))), "flags disagree with syndrome")

  `H2217TC_ASSERT(a_encode_clean, ((m_axis_tvalid && (r.codeword_out != '0)) |-> ((r.syndrome == '0) && (r.hours_out == '0) && (r.minutes_out == '0) && (r.seconds_out == '0) && !r.corrected && !r.uncorrectable)), "encode result carries decode fields")

endmodule

bind hamming_22_17_time_codec h2217tc_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/hamming_22_17_time_codec_tb.sv
`timescale 1ns / 1ps

module hamming_22_17_time_codec_tb;
  import h2217tc_pkg::*;

  typedef struct {
    op_t         op;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [21:0] codeword;
  } stamp_item_t;

  // Same bit order as m_axis_tdata[45:0].
  typedef struct packed {
    logic        uncorrectable;
    logic        corrected;
    logic [4:0]  syndrome;
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic [21:0] codeword;
  } stamp_result_t;

  localparam int RANDOM_ITEMS = 1150;
  localparam int PHASE_LEN    = 100;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 200;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [S_USER_W-1:0] s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  stamp_item_t   stamp_q[$];
  stamp_result_t decode_want_q[$];
  stamp_item_t   cur_item;
  int            sent_cnt = 0;
  int            hold_left = 0;
  logic          hold_done = 1'b0;
  int            fail_cnt = 0;
  int            phase;

  assign phase = (sent_cnt / PHASE_LEN) % 4;

  hamming_22_17_time_codec dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic logic is_check_pos(int p);
    return (p & (p - 1)) == 0;
  endfunction

  function automatic logic [4:0] hamming_syndrome(logic [21:0] w);
    logic [4:0] s;
    s = '0;
    for (int p = 1; p <= 22; p++) begin
      if (w[p-1]) s = s ^ p[4:0];
    end
    return s;
  endfunction

  function automatic logic [21:0] hamming_encode(logic [4:0] h, logic [5:0] m, logic [5:0] s);
    logic [16:0] data;
    logic [21:0] w;
    logic [4:0]  chk;
    int          k;
    data = {h, m, s};
    w = '0;
    k = 16;
    for (int p = 1; p <= 22; p++) begin
      if (!is_check_pos(p)) begin
        w[p-1] = data[k];
        k--;
      end
    end
    chk = hamming_syndrome(w);
    for (int j = 0; j < 5; j++) begin
      if (chk[j]) w[(1 << j) - 1] = 1'b1;
    end
    return w;
  endfunction

  function automatic stamp_result_t predict_result(stamp_item_t it);
    stamp_result_t r;
    logic [21:0]   w;
    logic [16:0]   data;
    int            k;
    r = '0;
    if (it.op == OP_ENCODE) begin
      r.codeword = hamming_encode(it.hours, it.minutes, it.seconds);
    end else begin
      w = it.codeword;
      r.syndrome = hamming_syndrome(w);
      if (r.syndrome != 0) begin
        if (r.syndrome <= 22) begin
          w[r.syndrome - 1] = ~w[r.syndrome - 1];
          r.corrected = 1'b1;
        end else begin
          r.uncorrectable = 1'b1;
        end
      end
      k = 16;
      data = '0;
      for (int p = 1; p <= 22; p++) begin
        if (!is_check_pos(p)) begin
          data[k] = w[p-1];
          k--;
        end
      end
      r.hours   = data[16:12];
      r.minutes = data[11:6];
      r.seconds = data[5:0];
    end
    return r;
  endfunction

  // Fields the operation does not use get random content.
  function automatic stamp_item_t make_item(op_t op, logic [4:0] h, logic [5:0] m,
                                            logic [5:0] s, logic [21:0] w);
    stamp_item_t it;
    it.op = op;
    if (op == OP_ENCODE) begin
      it.hours = h;
      it.minutes = m;
      it.seconds = s;
      it.codeword = 22'($urandom);
    end else begin
      it.hours = 5'($urandom);
      it.minutes = 6'($urandom);
      it.seconds = 6'($urandom);
      it.codeword = w;
    end
    return it;
  endfunction

  function automatic logic [21:0] pos_bit(int p);
    return 22'(1) << (p - 1);
  endfunction

  task automatic add_stamp(stamp_item_t it);
    stamp_q.insert(stamp_q.size(), it);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_want_q.insert(decode_want_q.size(), predict_result(cur_item));
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (stamp_q.size() != 0 &&
            (hold_left != 0 || (phase != 1 && phase != 3) ||
             $urandom_range(99) >= (phase == 3 ? 32 : 68))) begin
          cur_item = stamp_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= cur_item.op;
          s_axis_tdata <= {1'b0, cur_item.codeword, cur_item.seconds,
                           cur_item.minutes, cur_item.hours};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the pipeline fills and backs up the input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && sent_cnt >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    stamp_result_t got;
    stamp_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) &&
                       !((phase == 2 || phase == 3) &&
                         $urandom_range(99) < (phase == 3 ? 32 : 68));
      if (m_axis_tvalid && m_axis_tready) begin
        got = stamp_result_t'(m_axis_tdata[45:0]);
        if (decode_want_q.size() == 0) begin
          fail_cnt <= fail_cnt + 1;
          if (fail_cnt < 10) $display("unexpected result transfer: %h", m_axis_tdata);
        end else begin
          want = decode_want_q.pop_front();
          if (got.codeword !== want.codeword || got.hours !== want.hours ||
              got.minutes !== want.minutes || got.seconds !== want.seconds ||
              got.syndrome !== want.syndrome || got.corrected !== want.corrected ||
              got.uncorrectable !== want.uncorrectable) begin
            fail_cnt <= fail_cnt + 1;
            if (fail_cnt < 10) begin
              $display("mismatch: cw %h/%h h %0d/%0d m %0d/%0d s %0d/%0d",
                       want.codeword, got.codeword, want.hours, got.hours,
                       want.minutes, got.minutes, want.seconds, got.seconds);
              $display("          syn %0d/%0d corr %b/%b unc %b/%b (exp/act)",
                       want.syndrome, got.syndrome, want.corrected, got.corrected,
                       want.uncorrectable, got.uncorrectable);
            end
          end
        end
      end
    end
  end

  initial begin
    logic [21:0] w;
    logic [4:0]  h;
    logic [5:0]  m;
    logic [5:0]  s;
    int          a;
    int          b;
    int          pick;

    add_stamp(make_item(OP_ENCODE, 5'd0, 6'd0, 6'd0, '0));
    add_stamp(make_item(OP_ENCODE, 5'd31, 6'd63, 6'd63, '0));
    add_stamp(make_item(OP_ENCODE, 5'd31, 6'd0, 6'd0, '0));
    add_stamp(make_item(OP_ENCODE, 5'd0, 6'd63, 6'd0, '0));
    add_stamp(make_item(OP_ENCODE, 5'd0, 6'd0, 6'd63, '0));
    add_stamp(make_item(OP_ENCODE, 5'd21, 6'd42, 6'd21, '0));
    add_stamp(make_item(OP_ENCODE, 5'd10, 6'd21, 6'd42, '0));
    add_stamp(make_item(OP_DECODE, '0, '0, '0, 22'h000000));
    // all ones: syndrome 23, beyond the code length
    add_stamp(make_item(OP_DECODE, '0, '0, '0, 22'h3FFFFF));
    w = hamming_encode(5'd31, 6'd63, 6'd63);
    add_stamp(make_item(OP_DECODE, '0, '0, '0, w));
    add_stamp(make_item(OP_DECODE, '0, '0, '0, w ^ pos_bit(1)));
    w = hamming_encode(5'd12, 6'd34, 6'd56);
    add_stamp(make_item(OP_DECODE, '0, '0, '0, w ^ pos_bit(2)));
    add_stamp(make_item(OP_DECODE, '0, '0, '0, w ^ pos_bit(3)));
    add_stamp(make_item(OP_DECODE, '0, '0, '0, w ^ pos_bit(16)));
    add_stamp(make_item(OP_DECODE, '0, '0, '0, w ^ pos_bit(22)));
    // double errors: out of range syndromes and a miscorrection; then a single and a double error on the zero codeword
    add_stamp(make_item(OP_DECODE, '0, '0, '0, w ^ pos_bit(16) ^ pos_bit(7)));
    add_stamp(make_item(OP_DECODE, '0, '0, '0, w ^ pos_bit(16) ^ pos_bit(15)));
    add_stamp(make_item(OP_DECODE, '0, '0, '0, w ^ pos_bit(5) ^ pos_bit(6)));
    add_stamp(make_item(OP_DECODE, '0, '0, '0, pos_bit(22)));
    add_stamp(make_item(OP_DECODE, '0, '0, '0, pos_bit(16) | pos_bit(8)));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      h = 5'($urandom);
      m = 6'($urandom);
      s = 6'($urandom);
      pick = $urandom_range(99);
      if (pick < 30) begin
        add_stamp(make_item(OP_ENCODE, h, m, s, '0));
      end else begin
        w = hamming_encode(h, m, s);
        a = $urandom_range(22, 1);
        b = ((a + $urandom_range(20)) % 22) + 1;
        if (pick < 50) begin
          w = w;
        end else if (pick < 85) begin
          w = w ^ pos_bit(a);
        end else if (pick < 93) begin
          w = w ^ pos_bit(a) ^ pos_bit(b);
        end else begin
          w = 22'($urandom);
        end
        add_stamp(make_item(OP_DECODE, '0, '0, '0, w));
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (stamp_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (decode_want_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_cnt == 0 && decode_want_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
